@@ design/assert_macros.svh @@
// Shared assertion macros for the tile tag cache checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed on tile tag cache ports.");

// The consequent must hold in the cycle after the antecedent.
`define TTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed on tile tag cache ports.");

`endif

@@ design/ttc_pkg.sv @@
package ttc_pkg;

    localparam int DEF_ENTRIES    = 256;
    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_EPOCH_BITS = 16;

    localparam int IN_COORD_W = 16;
    localparam int LEVEL_W    = 4;
    localparam int IN_EPOCH_W = 16;
    localparam int IN_DATA_W  = 56;
    localparam int SLOT_W     = 8;
    localparam int OUT_USER_W = 3;

    localparam logic KIND_PROBE = 1'b0;
    localparam logic KIND_FILL  = 1'b1;

    localparam int FLAG_HIT      = 0;
    localparam int FLAG_INSERTED = 1;
    localparam int FLAG_EVICTED  = 2;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } ttc_state_t;

endpackage

@@ design/ttc_cell.sv @@
module ttc_cell #(
    parameter int KEY_W = 52,
    parameter int IDX_W = 8,
    parameter int CNT_W = 9,
    parameter int IDX   = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] query_key,
    input  logic [CNT_W-1:0] fill_count,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [KEY_W-1:0] wr_key,
    input  logic             prev_hit,
    input  logic [IDX_W-1:0] prev_slot,
    output logic             hit,
    output logic [IDX_W-1:0] slot
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             hit_reg;
    logic             hit_next;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] slot_next;
    logic             match;

    // An entry takes part only once the fill count has passed it.
    assign match = (CNT_W'(IDX) < fill_count) && (key_reg == query_key);

    always_comb
    begin
        key_next  = (wr_en && (wr_idx == IDX_W'(IDX))) ? wr_key : key_reg;
        hit_next  = prev_hit | match;
        slot_next = prev_hit ? prev_slot : IDX_W'(IDX);
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit  = hit_reg;
    assign slot = slot_reg;

endmodule

@@ design/ttc_chain.sv @@
module ttc_chain #(
    parameter int ENTRIES = 256,
    parameter int KEY_W   = 52,
    parameter int IDX_W   = 8,
    parameter int CNT_W   = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] query_key,
    input  logic [CNT_W-1:0] fill_count,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [KEY_W-1:0] wr_key,
    output logic             hit,
    output logic [IDX_W-1:0] slot
);

    logic             hit_link  [ENTRIES+1];
    logic [IDX_W-1:0] slot_link [ENTRIES+1];

    assign hit_link[0]  = 1'b0;
    assign slot_link[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        ttc_cell #(
            .KEY_W (KEY_W),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .query_key  (query_key),
            .fill_count (fill_count),
            .wr_en      (wr_en),
            .wr_idx     (wr_idx),
            .wr_key     (wr_key),
            .prev_hit   (hit_link[i]),
            .prev_slot  (slot_link[i]),
            .hit        (hit_link[i+1]),
            .slot       (slot_link[i+1])
        );
    end

    assign hit  = hit_link[ENTRIES];
    assign slot = slot_link[ENTRIES];

endmodule

@@ design/tile_tag_cache_fifo.sv @@
// Channel  Direction  Fields (lowest bit up)
// s_axis   in         tuser: kind; tdata: tile_col, tile_row, pyr_level, view_epoch
// m_axis   out        tuser: hit, inserted, evicted; tdata: slot
//
// The search token walks the row of cells, one cell per cycle, and the result is
// committed once the token has left the last cell and the output register is free.
// Reset empties the store at once through the fill count; no clearing pass is run.
// A finished result waits in the output register; a stalled output holds the next
// result inside the block until the register drains.
module tile_tag_cache_fifo
    import ttc_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int EPOCH_BITS = DEF_EPOCH_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // tile_col, tile_row, pyr_level, view_epoch
    input  logic                  s_axis_tuser,  // kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [SLOT_W-1:0]     m_axis_tdata,  // slot
    output logic [OUT_USER_W-1:0] m_axis_tuser   // hit, inserted, evicted
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 2 * COORD_BITS + LEVEL_W + EPOCH_BITS;
    localparam int SLOTX_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    ttc_state_t state_reg;
    ttc_state_t state_next;

    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      key_next;
    logic                  kind_reg;
    logic                  kind_next;
    logic [CNT_W-1:0]      scan_cnt_reg;
    logic [CNT_W-1:0]      scan_cnt_next;
    logic [CNT_W-1:0]      fill_count_reg;
    logic [CNT_W-1:0]      fill_count_next;
    logic [IDX_W-1:0]      oldest_reg;
    logic [IDX_W-1:0]      oldest_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [SLOT_W-1:0]     out_slot_next;
    logic [OUT_USER_W-1:0] out_flags_reg;
    logic [OUT_USER_W-1:0] out_flags_next;

    logic signed [IN_COORD_W-1:0] col_in;
    logic signed [IN_COORD_W-1:0] row_in;
    logic [31:0]                  col_wide;
    logic [31:0]                  row_wide;
    logic [31:0]                  epoch_wide;
    logic [KEY_W-1:0]             key_in;

    logic             in_accept;
    logic             scan_done;
    logic             commit;
    logic             chain_hit;
    logic [IDX_W-1:0] chain_slot;
    logic             miss_fill;
    logic             full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [SLOTX_W-1:0] res_slot;

    always_comb
    begin
        col_in     = s_axis_tdata[IN_COORD_W-1:0];
        row_in     = s_axis_tdata[2*IN_COORD_W-1:IN_COORD_W];
        col_wide   = 32'(col_in);
        row_wide   = 32'(row_in);
        epoch_wide = 32'(s_axis_tdata[2*IN_COORD_W+LEVEL_W+IN_EPOCH_W-1:2*IN_COORD_W+LEVEL_W]);
        key_in     = {col_wide[COORD_BITS-1:0], row_wide[COORD_BITS-1:0],
                      s_axis_tdata[2*IN_COORD_W+LEVEL_W-1:2*IN_COORD_W],
                      epoch_wide[EPOCH_BITS-1:0]};
    end

    ttc_chain #(
        .ENTRIES (ENTRIES),
        .KEY_W   (KEY_W),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .query_key  (key_reg),
        .fill_count (fill_count_reg),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .wr_key     (key_reg),
        .hit        (chain_hit),
        .slot       (chain_slot)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller.
    always_comb
    begin
        s_axis_tready = 1'b0;
        commit        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_SCAN:
            begin
                commit = scan_done && (!out_valid_reg || m_axis_tready);
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign scan_done = (scan_cnt_reg == CNT_W'(ENTRIES));

    always_comb
    begin
        full      = (fill_count_reg == CNT_W'(ENTRIES));
        miss_fill = (kind_reg == KIND_FILL) && !chain_hit;
        wr_idx    = full ? oldest_reg : fill_count_reg[IDX_W-1:0];
        wr_en     = commit && miss_fill;

        if (chain_hit)
        begin
            res_slot = SLOTX_W'(chain_slot);
        end
        else if (miss_fill)
        begin
            res_slot = SLOTX_W'(wr_idx);
        end
        else
        begin
            res_slot = '0;
        end

        key_next  = in_accept ? key_in : key_reg;
        kind_next = in_accept ? s_axis_tuser : kind_reg;

        if (in_accept)
        begin
            scan_cnt_next = '0;
        end
        else if ((state_reg == ST_SCAN) && !scan_done)
        begin
            scan_cnt_next = scan_cnt_reg + CNT_W'(1);
        end
        else
        begin
            scan_cnt_next = scan_cnt_reg;
        end

        fill_count_next = fill_count_reg;
        oldest_next     = oldest_reg;
        if (wr_en && !full)
        begin
            fill_count_next = fill_count_reg + CNT_W'(1);
        end
        if (wr_en && full)
        begin
            oldest_next = (oldest_reg == IDX_W'(ENTRIES - 1)) ? '0 : oldest_reg + IDX_W'(1);
        end

        out_slot_next  = out_slot_reg;
        out_flags_next = out_flags_reg;
        if (commit)
        begin
            out_valid_next                = 1'b1;
            out_slot_next                 = res_slot[SLOT_W-1:0];
            out_flags_next[FLAG_HIT]      = chain_hit;
            out_flags_next[FLAG_INSERTED] = miss_fill;
            out_flags_next[FLAG_EVICTED]  = miss_fill && full;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            fill_count_reg <= '0;
            oldest_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            fill_count_reg <= fill_count_next;
            oldest_reg     <= oldest_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        kind_reg      <= kind_next;
        out_slot_reg  <= out_slot_next;
        out_flags_reg <= out_flags_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_slot_reg;
    assign m_axis_tuser  = out_flags_reg;

endmodule

@@ design/ttc_checker.sv @@
`include "assert_macros.svh"

module ttc_checker
    import ttc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [SLOT_W-1:0]     m_axis_tdata,  // slot
    input logic [OUT_USER_W-1:0] m_axis_tuser   // hit, inserted, evicted
);

    logic                         stalled;
    logic                         in_xfer;
    logic [SLOT_W+OUT_USER_W-1:0] out_word;
    logic                         hit_flag;
    logic                         ins_flag;
    logic                         evict_flag;

    assign stalled    = m_axis_tvalid && !m_axis_tready;
    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign out_word   = {m_axis_tdata, m_axis_tuser};
    assign hit_flag   = m_axis_tuser[FLAG_HIT];
    assign ins_flag   = m_axis_tuser[FLAG_INSERTED];
    assign evict_flag = m_axis_tuser[FLAG_EVICTED];

    // A stalled result keeps its slot and flags.
    `TTC_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, m_axis_tvalid && $stable(out_word))

    // Only one request is in flight, so input is closed right after a transaction.
    `TTC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_xfer, !s_axis_tready)

    // A key that was found is never inserted again.
    `TTC_ASSERT_SAME(a_hit_no_insert, clk, rst_n, m_axis_tvalid, !(hit_flag && ins_flag))

    // An eviction is always part of an insert.
    `TTC_ASSERT_SAME(a_evict_insert, clk, rst_n, m_axis_tvalid && evict_flag, ins_flag)

endmodule

bind tile_tag_cache_fifo ttc_checker u_ttc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import ttc_pkg::*;

    localparam int N_ITEMS   = 1250;
    localparam int POOL_SIZE = 384;
    localparam int HOLD_LEN  = 2000;
    localparam int DRAIN_LEN = 2 * (DEF_ENTRIES + 2) + 100;
    localparam int MAX_CYC   = 2000000;

    typedef struct packed {
        logic [IN_EPOCH_W-1:0]        epoch;
        logic [LEVEL_W-1:0]           lvl;
        logic signed [IN_COORD_W-1:0] row;
        logic signed [IN_COORD_W-1:0] col;
    } tile_key_t;

    typedef struct packed {
        logic      kind;
        tile_key_t key;
    } tile_req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              inserted;
        logic              evicted;
    } lookup_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = KIND_PROBE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SLOT_W-1:0]     m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    tile_req_t  pending_q[$];
    lookup_t    lookup_q[$];
    tile_key_t  tag_mem[DEF_ENTRIES];
    int         tag_count = 0;
    logic [7:0] fifo_head = '0;

    tile_req_t cur_req;
    lookup_t   want;
    int        n_sent = 0;
    int        n_checked = 0;
    int        n_err = 0;
    int        n_hit = 0;
    int        n_insert = 0;
    int        n_evict = 0;
    int        n_probe_miss = 0;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        hold_cnt = 0;
    bit        hold_done = 1'b0;
    int        cycles = 0;

    tile_tag_cache_fifo DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always_comb
    begin
        if (n_sent < N_ITEMS / 3)
        begin
            tx_idle_pct = 35;
            rx_idle_pct = 64;
        end
        else if (n_sent < 2 * N_ITEMS / 3)
        begin
            tx_idle_pct = 64;
            rx_idle_pct = 35;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    function automatic tile_key_t make_key(int col, int row, int lvl, int epoch);
        tile_key_t k;
        k.col   = col[IN_COORD_W-1:0];
        k.row   = row[IN_COORD_W-1:0];
        k.lvl   = lvl[LEVEL_W-1:0];
        k.epoch = epoch[IN_EPOCH_W-1:0];
        return k;
    endfunction

    function automatic tile_key_t flip_bit(tile_key_t k, int b);
        return k ^ (52'd1 << b);
    endfunction

    function automatic tile_key_t random_key();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[51:0];
    endfunction

    // Searches the filled slots lowest first and, for a fill that misses, places the
    // key in the next free slot or over the oldest entry once the store is full.
    function automatic lookup_t tag_lookup(tile_req_t r);
        lookup_t o;
        int i;
        o = '0;
        for (i = 0; i < tag_count; i++)
        begin
            if (tag_mem[i] == r.key)
            begin
                o.hit  = 1'b1;
                o.slot = i[SLOT_W-1:0];
                break;
            end
        end
        if (!o.hit && r.kind == KIND_FILL)
        begin
            if (tag_count < DEF_ENTRIES)
            begin
                o.slot = tag_count[SLOT_W-1:0];
                tag_mem[tag_count] = r.key;
                tag_count++;
            end
            else
            begin
                o.slot = fifo_head;
                tag_mem[fifo_head] = r.key;
                fifo_head++;
                o.evicted = 1'b1;
            end
            o.inserted = 1'b1;
        end
        n_hit        += o.hit;
        n_insert     += o.inserted;
        n_evict      += o.evicted;
        n_probe_miss += (!o.hit && r.kind == KIND_PROBE);
        return o;
    endfunction

    task automatic push_req(logic kind, tile_key_t key);
        tile_req_t r;
        r.kind = kind;
        r.key  = key;
        pending_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= KIND_PROBE;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                lookup_q.push_back(tag_lookup(cur_req));
                n_sent <= n_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    cur_req = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0, cur_req.key};
                    s_axis_tuser  <= cur_req.kind;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Once in the last phase the receiver stops for a long stretch so that the
    // block backs up and holds off new requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && n_sent >= 2 * N_ITEMS / 3 + 10)
        begin
            if (hold_cnt == HOLD_LEN)
            begin
                hold_done     <= 1'b1;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                hold_cnt      <= hold_cnt + 1;
                m_axis_tready <= 1'b0;
            end
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (lookup_q.size() == 0)
            begin
                $error("Result transaction with no request waiting: slot %0d, flags %b",
                       m_axis_tdata, m_axis_tuser);
                n_err++;
            end
            else
            begin
                want = lookup_q.pop_front();
                if (m_axis_tuser[FLAG_HIT] !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, m_axis_tuser[FLAG_HIT]);
                    n_err++;
                end
                if (m_axis_tdata !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, m_axis_tdata);
                    n_err++;
                end
                if (m_axis_tuser[FLAG_INSERTED] !== want.inserted)
                begin
                    $error("inserted: expected %0d, got %0d", want.inserted,
                           m_axis_tuser[FLAG_INSERTED]);
                    n_err++;
                end
                if (m_axis_tuser[FLAG_EVICTED] !== want.evicted)
                begin
                    $error("evicted: expected %0d, got %0d", want.evicted,
                           m_axis_tuser[FLAG_EVICTED]);
                    n_err++;
                end
            end
            n_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == MAX_CYC)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, lookup_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        tile_key_t key_a;
        tile_key_t key_b;
        tile_key_t key_zero;
        tile_key_t key_ones;
        tile_key_t pool[POOL_SIZE];
        tile_key_t k;
        int        pick;
        int        i;

        key_a    = make_key(-32768, 32767, 0, 0);
        key_b    = make_key(32767, -32768, 15, 65535);
        key_zero = make_key(0, 0, 0, 0);
        key_ones = make_key(-1, -1, 15, 0);

        push_req(KIND_PROBE, key_a);
        push_req(KIND_FILL, key_a);
        push_req(KIND_PROBE, key_a);
        push_req(KIND_FILL, key_a);
        push_req(KIND_FILL, key_b);
        push_req(KIND_PROBE, key_b);
        push_req(KIND_PROBE, flip_bit(key_a, 0));
        push_req(KIND_PROBE, flip_bit(key_a, 16));
        push_req(KIND_PROBE, flip_bit(key_a, 32));
        push_req(KIND_PROBE, flip_bit(key_a, 51));
        push_req(KIND_FILL, flip_bit(key_a, 51));
        push_req(KIND_PROBE, key_a);
        push_req(KIND_FILL, key_zero);
        push_req(KIND_FILL, key_ones);
        push_req(KIND_PROBE, key_zero);
        push_req(KIND_FILL, key_b);
        push_req(KIND_PROBE, flip_bit(key_b, 15));
        push_req(KIND_FILL, flip_bit(key_ones, 31));
        push_req(KIND_PROBE, flip_bit(key_ones, 31));

        // A pool larger than the store gives both repeat hits and FIFO evictions.
        for (i = 0; i < POOL_SIZE; i++)
        begin
            pool[i] = random_key();
        end
        while (pending_q.size() < N_ITEMS)
        begin
            pick = $urandom_range(99);
            k = pool[$urandom_range(POOL_SIZE - 1)];
            if (pick < 70)
            begin
                push_req(($urandom_range(99) < 60) ? KIND_FILL : KIND_PROBE, k);
            end
            else if (pick < 80)
            begin
                push_req($urandom_range(1) ? KIND_FILL : KIND_PROBE,
                         flip_bit(k, $urandom_range(51)));
            end
            else
            begin
                push_req($urandom_range(1) ? KIND_FILL : KIND_PROBE, random_key());
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_axis_tvalid)
        begin
            @(posedge clk);
        end
        while (lookup_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_LEN) @(posedge clk);

        $display("Sent %0d lookups and checked %0d results in %0d cycles.",
                 n_sent, n_checked, cycles);
        $display("Saw %0d hits, %0d inserts, %0d evictions and %0d probe misses.",
                 n_hit, n_insert, n_evict, n_probe_miss);
        if (n_err == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
